// File: rtl/ils_pkg.sv
// Package for the indexed list store: sizes, request and status codes, and the
// payload structs of the request and result beats. No dependencies.
package ils_pkg;

  // Storage sizing.
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Fixed field widths of the beats.
  localparam int REQ_W   = 3;
  localparam int POS_W   = 7;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 7;
  localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

  // Request codes; the remaining code is ignored.
  typedef enum logic [REQ_W-1:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_APPEND = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_INSERT = 3'd4,
    REQ_ERASE  = 3'd5,
    REQ_CLEAR  = 3'd6
  } req_type_t;

  // Status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // What one storage cell does this cycle.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_cmd_t;

  // Request beat.
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] write_value;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [STAT_W-1:0] status;
    logic [OCNT_W-1:0] count;
    logic              is_empty;
  } out_item_t;

endpackage

// File: rtl/ils_cell.sv
// One storage cell of the list: holds a word, loads a new one, or takes the
// word of its lower or upper neighbour. Depends on ils_pkg.
module ils_cell
  import ils_pkg::*;
(
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] load_word,
  input  logic [DATA_WIDTH-1:0] lower_word,
  input  logic [DATA_WIDTH-1:0] upper_word,
  output logic [DATA_WIDTH-1:0] word
);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  // Select the next content of the cell.
  always_comb begin
    case (cmd)
      CELL_LOAD:       word_nxt = load_word;
      CELL_FROM_LOWER: word_nxt = lower_word;
      CELL_FROM_UPPER: word_nxt = upper_word;
      default:         word_nxt = word_r;
    endcase
  end

  // Payload register; its content is undefined until written.
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// File: rtl/indexed_list_store.sv
// Indexed list store: an ordered list of up to CAPACITY words in a row of cells.
// Latency: the result beat appears in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, as every request, insert
// and erase included, is carried out at once by moving all cells in parallel.
// Reset (rst_n low, synchronous) empties the list; stored words are undefined.
// The receiver cannot stall: each result is strobed by out_valid for one cycle.
module indexed_list_store
  import ils_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  out_item_t             out_item_r;
  out_item_t             out_item_nxt;

  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;
  logic [DATA_WIDTH-1:0] new_word;
  logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
  logic [DATA_WIDTH-1:0] sel_word;
  status_t               status;
  logic                  do_write;
  logic                  do_append;
  logic                  do_insert;
  logic                  do_erase;
  logic                  do_read;

  // No request ever stalls, so busy is tied low.
  assign busy = 1'b0;

  assign pos_x    = CMP_W'(in_item.position);
  assign cnt_x    = CMP_W'(count_r);
  assign new_word = DATA_WIDTH'(in_item.write_value);
  assign sel_word = cell_word[IDX_W'(in_item.position)];

  // Decode the request, check it against the count and work out the new count.
  always_comb begin
    status    = ST_OK;
    do_read   = 1'b0;
    do_write  = 1'b0;
    do_append = 1'b0;
    do_insert = 1'b0;
    do_erase  = 1'b0;
    count_nxt = count_r;
    case (req_type_t'(in_item.req_type))
      REQ_READ: begin
        if (pos_x < cnt_x) do_read = 1'b1;
        else status = ST_RANGE;
      end
      REQ_WRITE: begin
        if (pos_x < cnt_x) do_write = 1'b1;
        else status = ST_RANGE;
      end
      REQ_APPEND: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          do_append = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (count_r == '0) status = ST_EMPTY;
        else count_nxt = count_r - CNT_W'(1);
      end
      REQ_INSERT: begin
        if (pos_x > cnt_x) begin
          status = ST_RANGE;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          do_insert = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_ERASE: begin
        if (pos_x >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          do_erase  = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_CLEAR: count_nxt = '0;
      default:   ;
    endcase
    if (!start) begin
      do_write  = 1'b0;
      do_append = 1'b0;
      do_insert = 1'b0;
      do_erase  = 1'b0;
      count_nxt = count_r;
    end
  end

  // Row of cells; each one decides its own move from its place in the row.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CMP_W-1:0] PLACE = CMP_W'(g);
    cell_cmd_t             cmd;
    logic [DATA_WIDTH-1:0] lower_word;
    logic [DATA_WIDTH-1:0] upper_word;

    if (g == 0) begin : g_low_end
      assign lower_word = cell_word[g];
    end else begin : g_low_mid
      assign lower_word = cell_word[g-1];
    end

    if (g == CAPACITY - 1) begin : g_up_end
      assign upper_word = cell_word[g];
    end else begin : g_up_mid
      assign upper_word = cell_word[g+1];
    end

    always_comb begin
      cmd = CELL_HOLD;
      if ((do_write || do_insert) && PLACE == pos_x) cmd = CELL_LOAD;
      else if (do_append && PLACE == cnt_x)          cmd = CELL_LOAD;
      else if (do_insert && PLACE > pos_x)           cmd = CELL_FROM_LOWER;
      else if (do_erase && PLACE >= pos_x)           cmd = CELL_FROM_UPPER;
    end

    ils_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .load_word  (new_word),
      .lower_word (lower_word),
      .upper_word (upper_word),
      .word       (cell_word[g])
    );
  end

  // Result beat built from the request's outcome.
  always_comb begin
    out_item_nxt.read_data = do_read ? WORD_W'(sel_word) : '0;
    out_item_nxt.status    = status;
    out_item_nxt.count     = OCNT_W'(count_nxt);
    out_item_nxt.is_empty  = (count_nxt == '0);
  end

  // Count and strobe registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= start;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (start) out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The count never goes past the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list count beyond capacity");

  // Each taken request yields exactly one result beat in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_valid)
    else $error("request without result beat");

  // The count stays put while no request is taken.
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !start |=> $stable(count_r))
    else $error("count moved without a request");

  // A full refusal reports a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_FULL) |-> out_item.count == OCNT_W'(CAPACITY))
    else $error("full status with a list that is not full");

  // The reported count matches the count register.
  a_count_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.count == OCNT_W'(count_r)
                   && out_item.is_empty == (count_r == '0)))
    else $error("reported count differs from the stored count");

endmodule
